// ----- hw/rtl/mxs_pkg.sv -----
// Package with the item types and the action and status codes of the max stack.
`timescale 1ns / 1ps

package mxs_pkg;

	// Action codes
	localparam logic [1:0] ACT_PUSH    = 2'd0;
	localparam logic [1:0] ACT_POP     = 2'd1;
	localparam logic [1:0] ACT_POP_MAX = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Request item
	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] value;
	} cmd_item_t;

	// Result item
	typedef struct packed {
		logic signed [31:0] removed_value;
		logic [1:0]         status;
		logic signed [31:0] top_value;
		logic signed [31:0] max_value;
		logic [6:0]         entry_count;
	} res_item_t;

endpackage

// ----- hw/rtl/max_stack_core.sv -----
// Bounded stack of signed words with pop of the maximum, scanned by one shared compare unit.
// Every item ends with a scan of the stack for its top and maximum; a pop of the maximum
// first finds the maximum and then shifts the entries above it down by one place.
// A pop of either kind on an empty stack reports the empty status without reading.
// One item at a time: the next one is accepted in the cycle after the result is loaded;
// every scan and shift step goes through the single memory read port, one entry a cycle.
// Reset (arst_n low) empties the stack and the result register; no clearing pass.
`timescale 1ns / 1ps

module max_stack_core #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  mxs_pkg::cmd_item_t cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output mxs_pkg::res_item_t res
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FIND  = 5'b00010,
		S_SHIFT = 5'b00100,
		S_SCAN  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      scan_end_q;
	logic               rd_pend_q;
	logic [CW-1:0]      rd_idx_q;
	logic signed [31:0] rdata_q;
	logic signed [31:0] best_q;
	logic [CW-1:0]      best_idx_q;
	logic               best_vld_q;
	logic signed [31:0] top_q;
	logic signed [31:0] removed_q;
	logic [1:0]         status_q;
	logic               res_vld_q;
	mxs_pkg::res_item_t res_q;

	logic signed [31:0] mem_q [DEPTH];

	logic               cmd_accept;
	logic               in_phase;
	logic               issue;
	logic               phase_done;
	logic               data_ge;
	logic               out_free;
	logic               is_full;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic [CW-1:0]      shift_waddr;

	assign cmd_stall  = (state_q != S_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign out_free   = !res_vld_q || !res_stall;
	assign is_full    = (count_q == CW'(DEPTH));

	// Read sequencing shared by the find, shift and final scan phases
	assign in_phase   = (state_q == S_FIND) || (state_q == S_SHIFT) || (state_q == S_SCAN);
	assign issue      = in_phase && (idx_q < scan_end_q);
	assign phase_done = !issue && !rd_pend_q;

	// Shared signed compare: topmost wins on ties as the scan runs upwards
	assign data_ge = !best_vld_q || (rdata_q >= best_q);

	// Memory write: push at the top, or a shift step moving one entry down
	assign shift_waddr = rd_idx_q - CW'(1);
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = cmd.value;
		if (cmd_accept && (cmd.action == mxs_pkg::ACT_PUSH) && !is_full) begin
			mem_we = 1'b1;
		end else if ((state_q == S_SHIFT) && rd_pend_q) begin
			mem_we    = 1'b1;
			mem_waddr = shift_waddr[AW-1:0];
			mem_wdata = rdata_q;
		end
	end

	// Entry memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[idx_q[AW-1:0]];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			scan_end_q <= '0;
			rd_pend_q  <= 1'b0;
			rd_idx_q   <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			best_vld_q <= 1'b0;
			top_q      <= '0;
			removed_q  <= '0;
			status_q   <= mxs_pkg::ST_OK;
		end else begin
			rd_pend_q <= issue;
			rd_idx_q  <= idx_q;
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_accept) begin
						removed_q  <= '0;
						idx_q      <= '0;
						best_vld_q <= 1'b0;
						priority if ((cmd.action == mxs_pkg::ACT_PUSH) && is_full) begin
							status_q   <= mxs_pkg::ST_FULL;
							scan_end_q <= count_q;
							state_q    <= S_SCAN;
						end else if (cmd.action == mxs_pkg::ACT_PUSH) begin
							status_q   <= mxs_pkg::ST_OK;
							count_q    <= count_q + CW'(1);
							scan_end_q <= count_q + CW'(1);
							state_q    <= S_SCAN;
						end else if (((cmd.action == mxs_pkg::ACT_POP) ||
								(cmd.action == mxs_pkg::ACT_POP_MAX)) && (count_q == '0)) begin
							status_q   <= mxs_pkg::ST_EMPTY;
							scan_end_q <= count_q;
							state_q    <= S_SCAN;
						end else if (cmd.action == mxs_pkg::ACT_POP) begin
							// old top is read last and taken as the removed item
							status_q   <= mxs_pkg::ST_OK;
							count_q    <= count_q - CW'(1);
							scan_end_q <= count_q;
							state_q    <= S_SCAN;
						end else if (cmd.action == mxs_pkg::ACT_POP_MAX) begin
							status_q   <= mxs_pkg::ST_OK;
							scan_end_q <= count_q;
							state_q    <= S_FIND;
						end else begin
							// unused code: report the stack as it stands
							status_q   <= mxs_pkg::ST_OK;
							scan_end_q <= count_q;
							state_q    <= S_SCAN;
						end
					end
				end
				S_FIND: begin
					if (rd_pend_q && data_ge) begin
						best_q     <= rdata_q;
						best_idx_q <= rd_idx_q;
						best_vld_q <= 1'b1;
					end
					if (phase_done) begin
						removed_q  <= best_q;
						idx_q      <= best_idx_q + CW'(1);
						scan_end_q <= count_q;
						state_q    <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (phase_done) begin
						count_q    <= count_q - CW'(1);
						scan_end_q <= count_q - CW'(1);
						idx_q      <= '0;
						best_vld_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_pend_q) begin
						if (rd_idx_q < count_q) begin
							if (data_ge) begin
								best_q     <= rdata_q;
								best_vld_q <= 1'b1;
							end
							top_q <= rdata_q;
						end else begin
							removed_q <= rdata_q;
						end
					end
					if (phase_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			res_vld_q <= 1'b1;
		end else if (!res_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			res_q.removed_value <= removed_q;
			res_q.status        <= status_q;
			res_q.top_value     <= best_vld_q ? top_q : 32'sd0;
			res_q.max_value     <= best_vld_q ? best_q : 32'sd0;
			res_q.entry_count   <= 7'(count_q);
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule
